@@ rtl/gnl_pkg.sv @@
// Shared types, constants and list tables for the 2D grid neighbor lister.
package gnl_pkg;

    // Configuration register indexes.
    localparam logic CFG_COLUMN_COUNT  = 1'b0;
    localparam logic CFG_ELEMENT_COUNT = 1'b1;

    // Depth of the queue between the classifier and the emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Neighbor slots around an element, numbered in list order.
    localparam logic [2:0] SLOT_BELOW_LEFT  = 3'd0;
    localparam logic [2:0] SLOT_BELOW       = 3'd1;
    localparam logic [2:0] SLOT_BELOW_RIGHT = 3'd2;
    localparam logic [2:0] SLOT_LEFT        = 3'd3;
    localparam logic [2:0] SLOT_RIGHT       = 3'd4;
    localparam logic [2:0] SLOT_ABOVE_LEFT  = 3'd5;
    localparam logic [2:0] SLOT_ABOVE       = 3'd6;
    localparam logic [2:0] SLOT_ABOVE_RIGHT = 3'd7;

    // Where the queried element sits across its row.
    typedef enum logic [1:0] {
        KIND_INTERIOR,
        KIND_FIRST_COL,
        KIND_LAST_COL,
        KIND_NO_GRID
    } kind_t;

    // Classification of one query, handed from the front to the back.
    typedef struct packed {
        kind_t kind;
        logic  has_below;
        logic  has_above;
        logic  is_edge;
    } class_t;

    // Slot for a list position of each kind. Interior lists have eight
    // positions, edge-column lists five.
    function automatic logic [2:0] slot_of(kind_t kind, logic [2:0] pos);
        logic [2:0] slot;
        slot = SLOT_LEFT;
        case (kind)
            KIND_INTERIOR: slot = pos;
            KIND_FIRST_COL:
            begin
                case (pos)
                    3'd0:    slot = SLOT_BELOW;
                    3'd1:    slot = SLOT_BELOW_RIGHT;
                    3'd2:    slot = SLOT_RIGHT;
                    3'd3:    slot = SLOT_ABOVE_RIGHT;
                    default: slot = SLOT_ABOVE;
                endcase
            end
            KIND_LAST_COL:
            begin
                case (pos)
                    3'd0:    slot = SLOT_BELOW_LEFT;
                    3'd1:    slot = SLOT_BELOW;
                    3'd2:    slot = SLOT_LEFT;
                    3'd3:    slot = SLOT_ABOVE_LEFT;
                    default: slot = SLOT_ABOVE;
                endcase
            end
            default: slot = SLOT_LEFT;
        endcase
        return slot;
    endfunction

    // First list position: the row below is skipped when it does not exist.
    function automatic logic [2:0] list_start(kind_t kind, logic has_below);
        logic [2:0] pos;
        case (kind)
            KIND_INTERIOR:  pos = has_below ? 3'd0 : 3'd3;
            KIND_FIRST_COL: pos = has_below ? 3'd0 : 3'd2;
            KIND_LAST_COL:  pos = has_below ? 3'd0 : 3'd2;
            default:        pos = 3'd0;
        endcase
        return pos;
    endfunction

    // Final list position: the row above is dropped when it does not exist.
    function automatic logic [2:0] list_end(kind_t kind, logic has_above);
        logic [2:0] pos;
        case (kind)
            KIND_INTERIOR:  pos = has_above ? 3'd7 : 3'd4;
            KIND_FIRST_COL: pos = has_above ? 3'd4 : 3'd2;
            KIND_LAST_COL:  pos = has_above ? 3'd4 : 3'd2;
            default:        pos = 3'd0;
        endcase
        return pos;
    endfunction

endpackage

@@ rtl/gnl_front.sv @@
// Front end: row tests and a pipelined column remainder that classifies each query.
module gnl_front #(
    parameter int W = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [W-1:0]      column_count,
    input  logic [W-1:0]      element_count,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [W-1:0]      in_num,
    input  logic              q_full,
    output logic              q_wr,
    output logic [W-1:0]      q_num,
    output gnl_pkg::class_t   q_cls
);

    // Stage s holds the partial remainder after s numerator bits.
    logic         vld_reg  [0:W];
    logic [W-1:0] num_reg  [0:W];
    logic [W-1:0] rem_reg  [0:W];
    logic         hb_reg   [0:W];
    logic         ha_reg   [0:W];
    logic [W-1:0] rem_next [1:W];

    logic         advance;
    logic         hb_in;
    logic         ha_in;
    logic [W:0]   above_sum;
    logic [W-1:0] rem_final;

    // The whole pipeline moves unless its last stage is blocked by a full queue.
    assign advance  = !vld_reg[W] || !q_full;
    assign in_ready = advance;
    assign q_wr     = vld_reg[W] && !q_full;

    // A row above exists when number plus columns stays within the element count.
    assign above_sum = {1'b0, in_num} + {1'b0, column_count};
    assign hb_in     = in_num > column_count;
    assign ha_in     = above_sum <= {1'b0, element_count};

    // One restoring compare and subtract per stage.
    for (genvar s = 0; s < W; s++)
    begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        assign trial       = {rem_reg[s], num_reg[s][W-1-s]};
        assign diff        = trial - {1'b0, column_count};
        assign rem_next[s+1] = (trial >= {1'b0, column_count}) ? diff[W-1:0]
                                                                : trial[W-1:0];
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= W; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg[0] <= in_num;
            rem_reg[0] <= '0;
            hb_reg[0]  <= hb_in;
            ha_reg[0]  <= ha_in;
            for (int s = 1; s <= W; s++)
            begin
                num_reg[s] <= num_reg[s-1];
                rem_reg[s] <= rem_next[s];
                hb_reg[s]  <= hb_reg[s-1];
                ha_reg[s]  <= ha_reg[s-1];
            end
        end
    end

    // Classify the finished query for the queue.
    assign rem_final = rem_reg[W];
    assign q_num     = num_reg[W];

    always_comb
    begin
        q_cls.has_below = hb_reg[W];
        q_cls.has_above = ha_reg[W];
        if (column_count == '0)
        begin
            q_cls.kind = gnl_pkg::KIND_NO_GRID;
        end
        else if (rem_final == W'(1))
        begin
            q_cls.kind = gnl_pkg::KIND_FIRST_COL;
        end
        else if (rem_final == '0)
        begin
            q_cls.kind = gnl_pkg::KIND_LAST_COL;
        end
        else
        begin
            q_cls.kind = gnl_pkg::KIND_INTERIOR;
        end
        q_cls.is_edge = !hb_reg[W] || !ha_reg[W] || (q_cls.kind != gnl_pkg::KIND_INTERIOR);
    end

endmodule

@@ rtl/gnl_queue.sv @@
// Short queue of classified queries between the front and the back.
module gnl_queue #(
    parameter int W = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [W-1:0]      wr_num,
    input  gnl_pkg::class_t   wr_cls,
    output logic              full,
    input  logic              rd,
    output logic              empty,
    output logic [W-1:0]      rd_num,
    output gnl_pkg::class_t   rd_cls
);

    logic [W-1:0]            num_mem_reg [gnl_pkg::QUEUE_DEPTH];
    gnl_pkg::class_t         cls_mem_reg [gnl_pkg::QUEUE_DEPTH];
    logic [gnl_pkg::QPTR_W-1:0] wptr_reg;
    logic [gnl_pkg::QPTR_W-1:0] rptr_reg;
    logic [gnl_pkg::QCNT_W-1:0] count_reg;
    logic [gnl_pkg::QCNT_W-1:0] count_next;

    assign full   = count_reg == gnl_pkg::QCNT_W'(gnl_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign rd_num = num_mem_reg[rptr_reg];
    assign rd_cls = cls_mem_reg[rptr_reg];

    // Occupancy follows writes and reads.
    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            num_mem_reg[wptr_reg] <= wr_num;
            cls_mem_reg[wptr_reg] <= wr_cls;
        end
    end

endmodule

@@ rtl/gnl_back.sv @@
// Back end: walks the neighbor list of the queue head, one result word per cycle while the output is not stalled.
module gnl_back #(
    parameter int W = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [W-1:0]      column_count,
    input  logic              q_empty,
    input  logic [W-1:0]      q_num,
    input  gnl_pkg::class_t   q_cls,
    output logic              q_rd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [W-1:0]      out_neighbor,
    output logic              out_nvalid,
    output logic              out_edge,
    output logic              out_last
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] neighbor_reg;
    logic         nvalid_reg;
    logic         edge_reg;
    logic         last_reg;
    logic         started_reg;
    logic         started_next;
    logic [2:0]   pos_reg;
    logic [2:0]   pos_next;

    logic         load;
    logic         emit;
    logic [2:0]   cur_pos;
    logic [2:0]   end_pos;
    logic         is_last;
    logic [2:0]   slot;
    logic [W-1:0] row_base;
    logic [W-1:0] value;
    logic         no_grid;

    // The output register takes a new word when empty or being drained.
    assign load    = !out_valid_reg || out_ready;
    assign emit    = !q_empty && load;
    assign no_grid = q_cls.kind == gnl_pkg::KIND_NO_GRID;

    // Current list position of the head query.
    assign cur_pos = started_reg ? pos_reg
                                 : gnl_pkg::list_start(q_cls.kind, q_cls.has_below);
    assign end_pos = gnl_pkg::list_end(q_cls.kind, q_cls.has_above);
    assign is_last = cur_pos == end_pos;
    assign slot    = gnl_pkg::slot_of(q_cls.kind, cur_pos);
    assign q_rd    = emit && is_last;

    // Neighbor number: step a row, then a column, wrapping at the field width.
    always_comb
    begin
        if (slot == gnl_pkg::SLOT_BELOW_LEFT || slot == gnl_pkg::SLOT_BELOW
            || slot == gnl_pkg::SLOT_BELOW_RIGHT)
        begin
            row_base = q_num - column_count;
        end
        else if (slot == gnl_pkg::SLOT_ABOVE_LEFT || slot == gnl_pkg::SLOT_ABOVE
                 || slot == gnl_pkg::SLOT_ABOVE_RIGHT)
        begin
            row_base = q_num + column_count;
        end
        else
        begin
            row_base = q_num;
        end

        if (slot == gnl_pkg::SLOT_BELOW_LEFT || slot == gnl_pkg::SLOT_LEFT
            || slot == gnl_pkg::SLOT_ABOVE_LEFT)
        begin
            value = row_base - 1'b1;
        end
        else if (slot == gnl_pkg::SLOT_BELOW_RIGHT || slot == gnl_pkg::SLOT_RIGHT
                 || slot == gnl_pkg::SLOT_ABOVE_RIGHT)
        begin
            value = row_base + 1'b1;
        end
        else
        begin
            value = row_base;
        end
    end

    // Sequencer and output valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        started_next   = started_reg;
        pos_next       = pos_reg;
        if (load)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            started_next = !is_last;
            pos_next     = cur_pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            pos_reg       <= pos_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            neighbor_reg <= no_grid ? '0 : value;
            nvalid_reg   <= !no_grid;
            edge_reg     <= q_cls.is_edge;
            last_reg     <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_neighbor = neighbor_reg;
    assign out_nvalid   = nvalid_reg;
    assign out_edge     = edge_reg;
    assign out_last     = last_reg;

endmodule

@@ rtl/grid_neighbor_list_2d.sv @@
// Top level of the 2D structured grid neighbor lister.
// Each input word carries a one-based element number; the block answers with
// the element's neighbors in the order row below, same row, row above, one
// result word per neighbor, the final one marked with tlast. An element in the
// first or last column has up to five neighbors, any other up to eight, and a
// column count of zero gives one word flagged as not holding a neighbor. The
// front end finds the column remainder in a pipeline of ELEMENT_BITS
// compare-and-subtract stages; a query passes these stage registers, the
// queue and the output register before its first result leaves. The front
// takes a query every cycle while the four-entry queue has room; the back
// emits one result word per cycle while the output port is not stalled, with
// the words of consecutive queries back to back.
module grid_neighbor_list_2d #(
    parameter int ELEMENT_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wen,
    input  logic                                cfg_index,
    input  logic [ELEMENT_BITS-1:0]             cfg_data,
    // Query stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0: element_number.
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0: neighbor_element.
    output logic [((ELEMENT_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // tuser fields from bit 0: neighbor_valid, is_edge.
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int TDATA_W = ((ELEMENT_BITS + 7) / 8) * 8;

    logic [ELEMENT_BITS-1:0] column_count_reg;
    logic [ELEMENT_BITS-1:0] element_count_reg;

    logic                    q_wr;
    logic                    q_rd;
    logic                    q_full;
    logic                    q_empty;
    logic [ELEMENT_BITS-1:0] wr_num;
    logic [ELEMENT_BITS-1:0] rd_num;
    gnl_pkg::class_t         wr_cls;
    gnl_pkg::class_t         rd_cls;
    logic [ELEMENT_BITS-1:0] neighbor;
    logic                    nvalid;
    logic                    edge_flag;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= '0;
            element_count_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                gnl_pkg::CFG_COLUMN_COUNT:  column_count_reg  <= cfg_data;
                gnl_pkg::CFG_ELEMENT_COUNT: element_count_reg <= cfg_data;
                default:                    column_count_reg  <= column_count_reg;
            endcase
        end
    end

    gnl_front #(
        .W (ELEMENT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .column_count  (column_count_reg),
        .element_count (element_count_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_num        (s_axis_tdata[ELEMENT_BITS-1:0]),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_num         (wr_num),
        .q_cls         (wr_cls)
    );

    gnl_queue #(
        .W (ELEMENT_BITS)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_num (wr_num),
        .wr_cls (wr_cls),
        .full   (q_full),
        .rd     (q_rd),
        .empty  (q_empty),
        .rd_num (rd_num),
        .rd_cls (rd_cls)
    );

    gnl_back #(
        .W (ELEMENT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_count (column_count_reg),
        .q_empty      (q_empty),
        .q_num        (rd_num),
        .q_cls        (rd_cls),
        .q_rd         (q_rd),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_neighbor (neighbor),
        .out_nvalid   (nvalid),
        .out_edge     (edge_flag),
        .out_last     (m_axis_tlast)
    );

    // Pack the result word.
    assign m_axis_tdata = TDATA_W'(neighbor);
    assign m_axis_tuser = {edge_flag, nvalid};

endmodule
